FILE: src/array_list_insert_remove_defines.svh
// assertion macros shared by the list engine modules
`ifndef ARRAY_LIST_INSERT_REMOVE_DEFINES_SVH
`define ARRAY_LIST_INSERT_REMOVE_DEFINES_SVH

// checked on every clock edge outside reset
`define ALIR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ALIR_ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/alir_pkg.sv
package alir_pkg;

	localparam int CAPACITY_DEF    = 512;
	localparam int ENTRY_WIDTH_DEF = 16;

	localparam int FUNC_W  = 3;
	localparam int POS_W   = 10;
	localparam int VAL_W   = 16;
	localparam int OUT_W   = 16;
	localparam int ST_W    = 2;
	localparam int CNT_W   = 10;
	localparam int TDATA_W = 32;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REM_BACK  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_REM_AT    = 3'd5;
	localparam logic [FUNC_W-1:0] FN_READ_AT   = 3'd6;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_PUT,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		K_NOP,
		K_INS,
		K_REM,
		K_READ
	} kind_t;

	typedef struct packed {
		logic [CNT_W-1:0] entry_count;
		logic [ST_W-1:0]  status;
		logic [OUT_W-1:0] entry_out;
	} res_t;

endpackage

FILE: src/alir_mem.sv
module alir_mem #(
	parameter int CAPACITY    = alir_pkg::CAPACITY_DEF,
	parameter int ENTRY_WIDTH = alir_pkg::ENTRY_WIDTH_DEF,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [ENTRY_WIDTH-1:0] wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output logic [ENTRY_WIDTH-1:0] rdata
);

	logic [ENTRY_WIDTH-1:0] mem_q [CAPACITY];
	logic [ENTRY_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/alir_ctrl.sv
`include "array_list_insert_remove_defines.svh"

module alir_ctrl #(
	parameter int CAPACITY    = alir_pkg::CAPACITY_DEF,
	parameter int ENTRY_WIDTH = alir_pkg::ENTRY_WIDTH_DEF,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [alir_pkg::FUNC_W-1:0] func,
	input  logic [alir_pkg::POS_W-1:0]  position,
	input  logic [alir_pkg::VAL_W-1:0]  entry_value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output alir_pkg::res_t              res,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [ENTRY_WIDTH-1:0]      mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [ENTRY_WIDTH-1:0]      mem_rdata
);

	import alir_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	state_t state_q, state_d;
	logic [CW-1:0]          count_q;
	kind_t                  kind_q;
	logic [AW-1:0]          pos_q;
	logic [AW-1:0]          ptr_q;
	logic [AW-1:0]          stop_q;
	logic                   first_q;
	logic [ENTRY_WIDTH-1:0] val_q;
	logic [ST_W-1:0]        status_q;
	logic [OUT_W-1:0]       entry_q;
	logic                   v_s1;
	logic                   first_s1;
	logic [AW-1:0]          addr_s1;

	logic            accept;
	kind_t           dec_kind;
	logic            dec_ok;
	logic [ST_W-1:0] dec_status;
	logic [PW-1:0]   cnt_ext;
	logic [PW-1:0]   pos_ext;
	logic [PW-1:0]   tgt;
	logic [63:0]     val64;
	logic [63:0]     rd64;
	logic [PW-1:0]   cnt_out;

	assign accept  = in_valid && in_ready;
	assign cnt_ext = PW'(count_q);
	assign pos_ext = PW'(position);
	assign val64   = 64'(entry_value);
	assign rd64    = 64'(mem_rdata);

	// decode of the offered beat against the current count
	always_comb begin
		dec_kind   = K_NOP;
		dec_status = ST_OK;
		tgt        = '0;
		unique case (func) inside
			FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
				dec_kind = K_INS;
				if (func == FN_INS_BACK) begin
					tgt = cnt_ext;
				end else if (func == FN_INS_AT) begin
					tgt = pos_ext;
				end
				if (count_q == CW'(CAPACITY)) begin
					dec_status = ST_FULL;
				end else if (tgt > cnt_ext) begin
					dec_status = ST_RANGE;
				end
			end
			FN_REM_FRONT, FN_REM_BACK, FN_REM_AT, FN_READ_AT: begin
				dec_kind = (func == FN_READ_AT) ? K_READ : K_REM;
				if (func == FN_REM_BACK) begin
					tgt = cnt_ext - PW'(1);
				end else if (func == FN_REM_AT || func == FN_READ_AT) begin
					tgt = pos_ext;
				end
				if (count_q == '0) begin
					dec_status = ST_EMPTY;
				end else if (tgt >= cnt_ext) begin
					dec_status = ST_RANGE;
				end
			end
			default: begin
				dec_kind = K_NOP;
			end
		endcase
		dec_ok = (dec_status == ST_OK) && (dec_kind != K_NOP);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!dec_ok) begin
						state_d = S_DONE;
					end else if (dec_kind == K_INS && tgt == cnt_ext) begin
						state_d = S_PUT;
					end else begin
						state_d = S_RUN;
					end
				end
			end
			S_RUN: begin
				if (ptr_q == stop_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = (kind_q == K_INS) ? S_PUT : S_DONE;
			end
			S_PUT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs and memory port
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		mem_we    = 1'b0;
		mem_waddr = (kind_q == K_INS) ? addr_s1 + AW'(1) : addr_s1 - AW'(1);
		mem_wdata = mem_rdata;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_RUN, S_DRAIN: begin
				mem_re = (state_q == S_RUN);
				// first read of a removal or read returns the result, not a move
				mem_we = v_s1 && !(first_s1 && kind_q != K_INS);
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = val_q;
			end
			S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign cnt_out         = PW'(count_q);
	assign res.entry_out   = entry_q;
	assign res.status      = status_q;
	assign res.entry_count = cnt_out[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == S_RUN);
			if (accept && dec_ok) begin
				if (dec_kind == K_INS) begin
					count_q <= count_q + CW'(1);
				end else if (dec_kind == K_REM) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= dec_kind;
			status_q <= dec_status;
			entry_q  <= '0;
			pos_q    <= AW'(tgt);
			val_q    <= val64[ENTRY_WIDTH-1:0];
			first_q  <= (dec_kind != K_INS);
			if (dec_kind == K_INS) begin
				ptr_q  <= AW'(cnt_ext - PW'(1));
				stop_q <= AW'(tgt);
			end else begin
				ptr_q  <= AW'(tgt);
				stop_q <= (dec_kind == K_READ) ? AW'(tgt) : AW'(cnt_ext - PW'(1));
			end
		end
		if (state_q == S_RUN) begin
			addr_s1  <= ptr_q;
			first_s1 <= first_q;
			first_q  <= 1'b0;
			ptr_q    <= (kind_q == K_INS) ? ptr_q - AW'(1) : ptr_q + AW'(1);
		end
		if (v_s1 && first_s1 && kind_q != K_INS) begin
			entry_q <= rd64[OUT_W-1:0];
		end
	end

	`ALIR_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "list count beyond capacity")
	`ALIR_ASSERT(a_no_write_idle, (state_q == S_IDLE || state_q == S_DONE) |-> !mem_we, "store written outside an operation")
	`ALIR_ASSERT(a_count_hold, !(in_valid && in_ready) |=> $stable(count_q), "count moved without a new beat")
	`ALIR_ASSERT(a_leave_idle, (in_valid && in_ready) |=> (state_q != S_IDLE), "accepted beat not started")

endmodule

FILE: src/array_list_insert_remove.sv
// channel   dir  width  contents
// s_axis    in   32     command beat: func, position, entry_value
// m_axis    out  32     result beat: entry_out, status, entry_count
//
// one command at a time; the entry ram (one write, one read port, registered
// read) moves one entry per cycle; insert at place p into n entries moves
// entries n-1 down to p up, then writes the value at p (append: writes at once)
// remove at place p: entry p is read out as the result, later entries move down
// read at: entry p is read out; failed or unused commands: straight to result
// arst_n clears the count and handshakes; the ram needs no clearing pass
// a result waiting on m_tready does not block the next command from being
// taken; that command holds its own result until the output register frees
`include "array_list_insert_remove_defines.svh"

module array_list_insert_remove #(
	parameter int CAPACITY    = alir_pkg::CAPACITY_DEF,
	parameter int ENTRY_WIDTH = alir_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [2:0] func, [12:3] position, [28:13] entry_value, rest zero
	input  logic [alir_pkg::TDATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [15:0] entry_out, [17:16] status, [27:18] entry_count, rest zero
	output logic [alir_pkg::TDATA_W-1:0] m_tdata
);

	import alir_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RES_W = OUT_W + ST_W + CNT_W;

	// command fields unpacked from the slave beat
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  entry_value;

	assign func        = s_tdata[FUNC_W-1:0];
	assign position    = s_tdata[FUNC_W +: POS_W];
	assign entry_value = s_tdata[FUNC_W + POS_W +: VAL_W];

	logic res_valid;
	logic res_ready;
	res_t res;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [ENTRY_WIDTH-1:0] mem_wdata;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [ENTRY_WIDTH-1:0] mem_rdata;

	// sequencer: decode, count and the shift walk over the ram
	alir_ctrl #(
		.CAPACITY    (CAPACITY),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.func        (func),
		.position    (position),
		.entry_value (entry_value),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	// entry store
	alir_mem #(
		.CAPACITY    (CAPACITY),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: loads when empty or when its beat leaves this cycle
	logic             m_tvalid_q;
	logic [RES_W-1:0] m_res_q;

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(m_res_q);

	`ALIR_ASSERT_RST(a_rst_out, !arst_n |=> !m_tvalid, "result beat offered in reset")
	`ALIR_ASSERT(a_res_load, (res_valid && res_ready) |=> m_tvalid, "finished result not offered")
	`ALIR_ASSERT(a_busy_excl, (s_tvalid && s_tready) |-> !res_valid, "command taken while a result is pending")

endmodule

FILE: dv/array_list_insert_remove_tb.sv
`timescale 1ns / 100ps

module array_list_insert_remove_tb;
	import alir_pkg::*;

	// func code with no operation behind it, not named in the package
	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
	localparam int CAPACITY = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 700;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// [2:0] func, [12:3] position, [28:13] entry_value, rest zero
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// [15:0] entry_out, [17:16] status, [27:18] entry_count, rest zero
	logic [TDATA_W-1:0]   m_tdata;

	// when set, both sides run back to back with no idle cycles
	bit rushed = 1'b0;

	array_list_insert_remove u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// mirror of the ordered list plus the queue of results still owed
	class list_scoreboard;
		logic [VAL_W-1:0] entries [CAPACITY];
		int unsigned      cnt;
		int unsigned      peak;
		res_t             pending_results[$];
		int unsigned      errors;
		int unsigned      checked;
		int unsigned      op_hits[8];
		int unsigned      status_hits[4];

		function new();
			cnt = 0;
			peak = 0;
			errors = 0;
			checked = 0;
			foreach (op_hits[k]) op_hits[k] = 0;
			foreach (status_hits[k]) status_hits[k] = 0;
		endfunction

		// update the list for an accepted command beat and queue its result
		function void apply_cmd(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
				logic [VAL_W-1:0] val);
			res_t        r;
			int unsigned p;
			int unsigned i;
			r = '0;
			r.status = ST_OK;
			op_hits[fn]++;
			case (fn)
				FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
					if (cnt >= CAPACITY) begin
						// full is reported ahead of a bad position
						r.status = ST_FULL;
					end else begin
						p = (fn == FN_INS_FRONT) ? 0 : (fn == FN_INS_BACK) ? cnt : pos;
						if (p > cnt) begin
							r.status = ST_RANGE;
						end else begin
							// open a gap at p, later entries move up
							for (i = cnt; i > p; i--) entries[i] = entries[i - 1];
							entries[p] = val;
							cnt++;
						end
					end
				end
				FN_REM_FRONT, FN_REM_BACK, FN_REM_AT, FN_READ_AT: begin
					if (cnt == 0) begin
						r.status = ST_EMPTY;
					end else begin
						p = (fn == FN_REM_FRONT) ? 0 : (fn == FN_REM_BACK) ? cnt - 1 : pos;
						if (p >= cnt) begin
							r.status = ST_RANGE;
						end else if (fn == FN_READ_AT) begin
							r.entry_out = entries[p];
						end else begin
							// take out entry p, later entries move down
							r.entry_out = entries[p];
							cnt--;
							for (i = p; i < cnt; i++) entries[i] = entries[i + 1];
						end
					end
				end
				default: begin
					// unused code leaves everything as it was
				end
			endcase
			r.entry_count = CNT_W'(cnt);
			if (cnt > peak) peak = cnt;
			status_hits[r.status]++;
			pending_results.push_back(r);
		endfunction

		function void note_error(string what, logic [31:0] exp_v, logic [31:0] got_v);
			errors++;
			$display("%0t: %s mismatch, expected %0h got %0h", $time, what, exp_v, got_v);
		endfunction

		// compare one accepted result beat with the oldest expectation
		function void check_result(logic [TDATA_W-1:0] beat);
			res_t exp_r;
			res_t got_r;
			got_r = beat[$bits(res_t)-1:0];
			checked++;
			if (pending_results.size() == 0) begin
				note_error("unexpected result beat", '0, beat);
				return;
			end
			exp_r = pending_results.pop_front();
			if (got_r.entry_out !== exp_r.entry_out)
				note_error("entry_out", 32'(exp_r.entry_out), 32'(got_r.entry_out));
			if (got_r.status !== exp_r.status)
				note_error("status", 32'(exp_r.status), 32'(got_r.status));
			if (got_r.entry_count !== exp_r.entry_count)
				note_error("entry_count", 32'(exp_r.entry_count), 32'(got_r.entry_count));
		endfunction
	endclass

	list_scoreboard sb;

	initial begin
		forever #6 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("array_list_insert_remove_tb NOT OK");
		$finish;
	end

	function automatic int draw_gap();
		if (rushed) return 0;
		return $urandom_range(0, 18);
	endfunction

	// idle for a random gap, then present one command beat until taken
	task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'({val, pos, fn});
		do @(posedge clk); while (!s_tready);
		sb.apply_cmd(fn, pos, val);
	endtask

	// pick a random command, mostly inserts when ins_pct is high
	task automatic random_cmd(input int ins_pct);
		int               roll;
		logic [FUNC_W-1:0] fn;
		logic [POS_W-1:0]  pos;
		logic [VAL_W-1:0]  val;
		roll = $urandom_range(0, 99);
		val  = VAL_W'($urandom());
		pos  = POS_W'($urandom());
		if (roll < ins_pct) begin
			case ($urandom_range(0, 2))
				0:       fn = FN_INS_FRONT;
				1:       fn = FN_INS_BACK;
				default: fn = FN_INS_AT;
			endcase
		end else if (roll < 98) begin
			case ($urandom_range(0, 3))
				0:       fn = FN_REM_FRONT;
				1:       fn = FN_REM_BACK;
				2:       fn = FN_REM_AT;
				default: fn = FN_READ_AT;
			endcase
		end else begin
			fn = FN_UNUSED;
		end
		// most positioned commands land inside the list, the rest anywhere
		if ($urandom_range(0, 99) < 85) begin
			if (fn == FN_INS_AT)
				pos = POS_W'($urandom_range(0, sb.cnt));
			else if ((fn == FN_REM_AT || fn == FN_READ_AT) && sb.cnt > 0)
				pos = POS_W'($urandom_range(0, sb.cnt - 1));
		end
		send_cmd(fn, pos, val);
	endtask

	// stop sending and let every owed result come back
	task automatic wait_drained();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (sb.pending_results.size() != 0 && guard < 20000);
	endtask

	// result side: random stall per beat, then take one beat
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		int n;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every removal and read fails, an insert past the count fails, unused code is a no-op
		send_cmd(FN_REM_FRONT, 10'd0, 16'h0000);
		send_cmd(FN_REM_BACK, 10'd0, 16'h0000);
		send_cmd(FN_REM_AT, 10'd0, 16'h0000);
		send_cmd(FN_READ_AT, 10'h3ff, 16'hffff);
		send_cmd(FN_UNUSED, 10'h3ff, 16'hffff);
		send_cmd(FN_INS_AT, 10'd1, 16'h1111);
		// build a short list with every insert flavor, extremes of the handle
		send_cmd(FN_INS_FRONT, 10'h3ff, 16'hffff);
		send_cmd(FN_INS_BACK, 10'd0, 16'h0000);
		send_cmd(FN_INS_AT, 10'd1, 16'ha5a5);
		send_cmd(FN_INS_AT, 10'd3, 16'h5a5a);
		send_cmd(FN_INS_AT, 10'd0, 16'h1234);
		// insert positions past the count
		send_cmd(FN_INS_AT, 10'd6, 16'hbeef);
		send_cmd(FN_INS_AT, 10'h3ff, 16'hbeef);
		// reads at both ends and past the end
		send_cmd(FN_READ_AT, 10'd0, 16'h0000);
		send_cmd(FN_READ_AT, 10'd4, 16'h0000);
		send_cmd(FN_READ_AT, 10'd5, 16'h0000);
		send_cmd(FN_READ_AT, 10'h3ff, 16'h0000);
		// removals down to empty
		send_cmd(FN_REM_AT, 10'd5, 16'h0000);
		send_cmd(FN_REM_AT, 10'd2, 16'h0000);
		send_cmd(FN_REM_BACK, 10'h3ff, 16'hffff);
		send_cmd(FN_REM_FRONT, 10'h3ff, 16'hffff);
		send_cmd(FN_UNUSED, 10'd0, 16'h0000);
		send_cmd(FN_REM_AT, 10'd1, 16'h0000);
		send_cmd(FN_REM_AT, 10'd0, 16'h0000);
		send_cmd(FN_READ_AT, 10'd0, 16'h0000);

		// fill to capacity with insert-heavy traffic, then hit the full case
		n = 0;
		while (sb.cnt < CAPACITY || n < 600) begin
			if (n % 40 == 0) rushed = ($urandom_range(0, 3) == 0);
			random_cmd((sb.cnt < CAPACITY) ? 90 : 60);
			n++;
			if (sb.cnt == CAPACITY && sb.op_hits[FN_INS_FRONT] > 0 &&
					sb.status_hits[ST_FULL] >= 12) break;
		end
		rushed = 1'b0;

		// hold off until the engine has answered everything
		wait_drained();

		// remove-heavy from the top, then balanced traffic
		while (n < RANDOM_ITEMS) begin
			if (n % 40 == 0) rushed = ($urandom_range(0, 3) == 0);
			random_cmd((n < RANDOM_ITEMS - 60) ? 15 : 50);
			n++;
		end
		rushed = 1'b0;

		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending_results.size());
			sb.errors++;
		end

		$display("covered %0d commands: %0d inserts, %0d removals, %0d reads, %0d unused;"
			, sb.op_hits.sum(), sb.op_hits[0] + sb.op_hits[1] + sb.op_hits[2],
			sb.op_hits[3] + sb.op_hits[4] + sb.op_hits[5], sb.op_hits[6], sb.op_hits[7]);
		$display("list peaked at %0d; statuses ok %0d full %0d empty %0d range %0d",
			sb.peak, sb.status_hits[ST_OK], sb.status_hits[ST_FULL],
			sb.status_hits[ST_EMPTY], sb.status_hits[ST_RANGE]);
		if (sb.errors == 0)
			$display("array_list_insert_remove_tb OK");
		else
			$display("array_list_insert_remove_tb NOT OK");
		$finish;
	end

endmodule
